@@ hdl/sip_pkg.sv @@
package sip_pkg;

	// Fixed-point format of coordinates, mass and results.
	localparam int FRAC_BITS = 16;
	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	// Divider geometry: numerator, divisor and quotient widths.
	localparam int QW = 32;
	localparam int DW = 64;
	localparam int NW = 64 + FRAC_BITS;
	localparam int DIV_LAT = QW;

	// Square root of a 64-bit radicand takes one result bit per stage.
	localparam int SQRT_LAT = 32;

	// Derived internal widths.
	localparam int CM_W = FRAC_BITS + 2;
	localparam int W_W = FRAC_BITS + 1;
	localparam int TWO_R_W = 33;
	localparam int D_W = 34;

	// Saturation limits of the divider results.
	localparam logic [31:0] CAP_SMAX = 32'h7FFF_FFFF;
	localparam logic [31:0] CAP_SMIN = 32'h8000_0000;
	localparam logic [31:0] CAP_M32 = 32'hFFFF_FFFF;
	localparam logic [31:0] CAP_ONE = ONE;
	localparam logic [31:0] CAP_T3 = 32'(3 * (64'd1 << FRAC_BITS));

	// Index pairs of the symmetric second-derivative tensor: xx xy xz yy yz zz.
	localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

	// Configuration port.
	localparam int ADDR_W = 3;

	typedef enum logic [0:0] {
		REG_MASS = 1'b0,
		REG_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] mass;
		logic        conformal_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic signed [31:0] z_pos;
	} pt_t;

	typedef struct packed {
		logic signed [31:0] psi_out;
		logic signed [31:0] lapse;
		logic signed [31:0] gb_diag;
		logic signed [31:0] dpsi_x;
		logic signed [31:0] dpsi_y;
		logic signed [31:0] dpsi_z;
		logic signed [31:0] ddpsi_xx;
		logic signed [31:0] ddpsi_xy;
		logic signed [31:0] ddpsi_xz;
		logic signed [31:0] ddpsi_yy;
		logic signed [31:0] ddpsi_yz;
		logic signed [31:0] ddpsi_zz;
	} res_t;

	// Clamp a divider quotient, with its overflow flag, to a limit.
	function automatic logic [31:0] capq(input logic ovf, input logic [31:0] q,
			input logic [31:0] cap);
		return (ovf || (q > cap)) ? cap : q;
	endfunction

	// Build a saturated two's complement word from sign and magnitude.
	function automatic logic [31:0] pack_s(input logic neg, input logic [31:0] mag);
		logic [31:0] m;
		if (neg) begin
			m = (mag > CAP_SMIN) ? CAP_SMIN : mag;
			return 32'(0) - m;
		end
		return (mag > CAP_SMAX) ? CAP_SMAX : mag;
	endfunction

endpackage

@@ hdl/sip_cfg.sv @@
module sip_cfg import sip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [30:0] mass_q;
	logic        mode_q;
	reg_idx_t    idx;
	logic        wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= ONE[30:0];
			mode_q <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_MASS: mass_q <= pwdata[30:0];
				REG_MODE: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			REG_MASS: prdata = {1'b0, mass_q};
			REG_MODE: prdata = {31'd0, mode_q};
			default:  prdata = '0;
		endcase
	end

	assign cfg.mass           = mass_q;
	assign cfg.conformal_mode = mode_q;

endmodule

@@ hdl/sip_sqrt.sv @@
module sip_sqrt import sip_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [63:0] v_s   [SQRT_LAT];
	logic [63:0] res_s [SQRT_LAT];

	// One result bit per stage, from the top bit pair down.
	for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
		localparam logic [63:0] BIT_J = 64'd1 << (62 - 2 * j);
		logic [63:0] v_i;
		logic [63:0] res_i;
		logic [64:0] trial;
		logic        take;

		if (j == 0) begin : g_first
			assign v_i   = rad;
			assign res_i = '0;
		end else begin : g_next
			assign v_i   = v_s[j-1];
			assign res_i = res_s[j-1];
		end

		assign trial = {1'b0, res_i} + {1'b0, BIT_J};
		assign take  = {1'b0, v_i} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[j]   <= take ? (v_i - trial[63:0]) : v_i;
				res_s[j] <= take ? ((res_i >> 1) + BIT_J) : (res_i >> 1);
			end
		end
	end

	assign root = res_s[SQRT_LAT-1][31:0];

endmodule

@@ hdl/sip_div.sv @@
module sip_div import sip_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);

	localparam int HI_W = NW - QW;

	logic [DW-1:0] rem_s [DIV_LAT];
	logic [DW-1:0] den_s [DIV_LAT];
	logic [QW-1:0] lo_s  [DIV_LAT];
	logic [QW-1:0] quo_s [DIV_LAT];
	logic          ovf_s [DIV_LAT];

	// Restoring division, one quotient bit per stage. The first stage also
	// flags a quotient that does not fit in QW bits.
	for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] lo_i;
		logic [QW-1:0] quo_i;
		logic          ovf_i;
		logic [DW:0]   trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_i = DW'(num[NW-1:QW]);
			assign den_i = den;
			assign lo_i  = num[QW-1:0];
			assign quo_i = '0;
			assign ovf_i = {{(DW - HI_W){1'b0}}, num[NW-1:QW]} >= den;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign den_i = den_s[j-1];
			assign lo_i  = lo_s[j-1];
			assign quo_i = quo_s[j-1];
			assign ovf_i = ovf_s[j-1];
		end

		assign trial = {rem_i, lo_i[QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
				den_s[j] <= den_i;
				lo_s[j]  <= {lo_i[QW-2:0], 1'b0};
				quo_s[j] <= {quo_i[QW-2:0], take};
				ovf_s[j] <= ovf_i;
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];
	assign ovf = ovf_s[DIV_LAT-1];

endmodule

@@ hdl/schwarzschild_isotropic_point.sv @@
// Pipelined isotropic Schwarzschild evaluator: one grid point per cycle while no
// result is held. Each point passes a 32-stage square root and three chained
// rounds of 32-stage dividers plus seven single register stages.
// Throughput is one beat per cycle; a held result freezes the whole pipeline.
// Reset clears all valid bits and sets mass to 1.0 and conformal mode on.
module schwarzschild_isotropic_point import sip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pt_valid,
	output logic              pt_stall,
	input  pt_t               pt_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef struct packed {
		logic [5:0][63:0] prod;
		logic [63:0]      r2;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
	} sd1_t;

	typedef struct packed {
		logic [31:0]      root;
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             lneg;
	} sd2_t;

	typedef struct packed {
		logic [31:0]           p;
		logic [31:0]           lapse;
		logic [5:0]            cneg;
		logic [5:0][CM_W-1:0]  cm;
		logic [31:0]           root;
		logic [2:0][31:0]      mag;
		logic [2:0]            neg;
	} sd3_t;

	typedef struct packed {
		logic [2:0]  dneg;
		logic [5:0]  cneg;
		logic [31:0] p;
		logic [31:0] p2;
		logic [31:0] lapse;
	} sd4_t;

	cfg_t cfg;
	logic en;

	sip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The pipeline advances unless a finished result is held.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic vsq_q [SQRT_LAT];
	logic vd1_q [DIV_LAT];
	logic vd2_q [DIV_LAT];
	logic vd3_q [DIV_LAT];

	assign en        = !(v_s7 && res_stall);
	assign pt_stall  = !en;
	assign res_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < SQRT_LAT; k++) vsq_q[k] <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				vd1_q[k] <= 1'b0;
				vd2_q[k] <= 1'b0;
				vd3_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= pt_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			vsq_q[0] <= v_s3;
			for (int k = 1; k < SQRT_LAT; k++) vsq_q[k] <= vsq_q[k-1];
			v_s4     <= vsq_q[SQRT_LAT-1];
			vd1_q[0] <= v_s4;
			v_s5     <= vd1_q[DIV_LAT-1];
			vd2_q[0] <= v_s5;
			v_s6     <= vd2_q[DIV_LAT-1];
			vd3_q[0] <= v_s6;
			v_s7     <= vd3_q[DIV_LAT-1];
			for (int k = 1; k < DIV_LAT; k++) begin
				vd1_q[k] <= vd1_q[k-1];
				vd2_q[k] <= vd2_q[k-1];
				vd3_q[k] <= vd3_q[k-1];
			end
		end
	end

	// Stage 1: split coordinates into sign and magnitude.
	logic [2:0][31:0] pos;
	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;

	assign pos[0] = pt_data.x_pos;
	assign pos[1] = pt_data.y_pos;
	assign pos[2] = pt_data.z_pos;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= pos[i][31];
				mag_s1[i] <= pos[i][31] ? (32'd0 - pos[i]) : pos[i];
			end
		end
	end

	// Stage 2: squares and cross products of the magnitudes.
	logic [5:0][63:0] prod_s2;
	logic [2:0][31:0] mag_s2;
	logic [2:0]       neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) begin
				prod_s2[k] <= 64'(mag_s1[PAIR_A[k]]) * 64'(mag_s1[PAIR_B[k]]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// Stage 3: squared radius.
	sd1_t sd1_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sd1_s3.r2   <= prod_s2[0] + prod_s2[3] + prod_s2[5];
			sd1_s3.prod <= prod_s2;
			sd1_s3.mag  <= mag_s2;
			sd1_s3.neg  <= neg_s2;
		end
	end

	// Square root, with the point's data delayed alongside.
	logic [31:0] root;
	sd1_t        sd1_q [SQRT_LAT];

	sip_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sd1_s3.r2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd1_q[0] <= sd1_s3;
			for (int k = 1; k < SQRT_LAT; k++) sd1_q[k] <= sd1_q[k-1];
		end
	end

	// Stage 4: radius terms and numerators of the first division round.
	sd1_t               sd1_e;
	logic [31:0]        r_fix;
	logic [TWO_R_W-1:0] two_r;
	logic [TWO_R_W-1:0] mass_x;

	logic [D_W-1:0]     d_s4;
	logic [TWO_R_W-1:0] two_r_s4;
	logic [TWO_R_W-1:0] num_s4;
	logic [5:0][63:0]   tnum_s4;
	logic [63:0]        divt_s4;
	sd2_t               sd2_s4;

	assign sd1_e  = sd1_q[SQRT_LAT-1];
	assign r_fix  = (root == 32'd0) ? 32'd1 : root;
	assign two_r  = {r_fix, 1'b0};
	assign mass_x = TWO_R_W'(cfg.mass);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4        <= D_W'(two_r) + D_W'(mass_x);
			two_r_s4    <= two_r;
			num_s4      <= (mass_x > two_r) ? (mass_x - two_r) : (two_r - mass_x);
			for (int k = 0; k < 6; k++) begin
				tnum_s4[k] <= sd1_e.prod[k] + {sd1_e.prod[k][62:0], 1'b0};
			end
			divt_s4     <= (sd1_e.r2 == 64'd0) ? 64'd1 : sd1_e.r2;
			sd2_s4.root <= r_fix;
			sd2_s4.mag  <= sd1_e.mag;
			sd2_s4.neg  <= sd1_e.neg;
			sd2_s4.lneg <= mass_x > two_r;
		end
	end

	// First division round: psi, lapse, M/D and the direction products.
	logic [QW-1:0] q_psi, q_lap, q_w;
	logic          o_psi, o_lap, o_w;
	logic [QW-1:0] q_t [6];
	logic          o_t [6];

	sip_div u_div_psi (
		.clk (clk), .en (en),
		.num (NW'(d_s4) << FRAC_BITS), .den (DW'(two_r_s4)),
		.quo (q_psi), .ovf (o_psi)
	);

	sip_div u_div_lap (
		.clk (clk), .en (en),
		.num (NW'(num_s4) << FRAC_BITS), .den (DW'(d_s4)),
		.quo (q_lap), .ovf (o_lap)
	);

	sip_div u_div_w (
		.clk (clk), .en (en),
		.num (NW'(cfg.mass) << FRAC_BITS), .den (DW'(d_s4)),
		.quo (q_w), .ovf (o_w)
	);

	for (genvar k = 0; k < 6; k++) begin : g_div_t
		sip_div u_div_t (
			.clk (clk), .en (en),
			.num (NW'(tnum_s4[k]) << FRAC_BITS), .den (divt_s4),
			.quo (q_t[k]), .ovf (o_t[k])
		);
	end

	sd2_t sd2_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sd2_q[0] <= sd2_s4;
			for (int k = 1; k < DIV_LAT; k++) sd2_q[k] <= sd2_q[k-1];
		end
	end

	// Stage 5: saturate, form the lapse and the tensor coefficients.
	sd2_t                 sd2_e;
	logic [5:0]           cneg_c;
	logic [5:0][CM_W-1:0] cm_c;
	sd3_t                 sd3_s5;
	logic [W_W-1:0]       w_s5;
	logic [31:0]          w_cap;

	assign sd2_e = sd2_q[DIV_LAT-1];
	assign w_cap = capq(o_w, q_w, CAP_ONE);

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			logic [31:0]     tq;
			logic [CM_W-1:0] t;
			logic            cn;
			logic [CM_W-1:0] cmv;
			tq = capq(o_t[k], q_t[k], CAP_T3);
			t  = tq[CM_W-1:0];
			if (PAIR_A[k] == PAIR_B[k]) begin
				cn  = t < CM_W'(ONE);
				cmv = cn ? (CM_W'(ONE) - t) : (t - CM_W'(ONE));
			end else begin
				cn  = (sd2_e.neg[PAIR_A[k]] != sd2_e.neg[PAIR_B[k]]) && (t != '0);
				cmv = t;
			end
			cneg_c[k] = cn && (cmv != '0);
			cm_c[k]   = cmv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd3_s5.p     <= capq(o_psi, q_psi, cfg.conformal_mode ? CAP_SMAX : CAP_M32);
			sd3_s5.lapse <= pack_s(sd2_e.lneg, capq(o_lap, q_lap, CAP_SMIN));
			sd3_s5.cneg  <= cneg_c;
			sd3_s5.cm    <= cm_c;
			sd3_s5.root  <= sd2_e.root;
			sd3_s5.mag   <= sd2_e.mag;
			sd3_s5.neg   <= sd2_e.neg;
			w_s5         <= w_cap[W_W-1:0];
		end
	end

	// Second division round: the common factor K.
	logic [QW-1:0] q_k;
	logic          o_k;

	sip_div u_div_k (
		.clk (clk), .en (en),
		.num (NW'(w_s5) << FRAC_BITS), .den (DW'(sd3_s5.root)),
		.quo (q_k), .ovf (o_k)
	);

	sd3_t sd3_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sd3_q[0] <= sd3_s5;
			for (int k = 1; k < DIV_LAT; k++) sd3_q[k] <= sd3_q[k-1];
		end
	end

	// Stage 6: scale by K and square psi.
	sd3_t             sd3_e;
	logic [31:0]      k_fac;
	logic [63:0]      pp;
	logic [63:0]      pp_sh;
	logic [2:0][63:0] prodm_s6;
	logic [5:0][63:0] prodc_s6;
	logic [31:0]      root_s6;
	sd4_t             sd4_s6;

	assign sd3_e = sd3_q[DIV_LAT-1];
	assign k_fac = capq(o_k, q_k, CAP_M32);
	assign pp    = 64'(sd3_e.p) * 64'(sd3_e.p);
	assign pp_sh = pp >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prodm_s6[i]       <= 64'(sd3_e.mag[i]) * 64'(k_fac);
				sd4_s6.dneg[i]    <= !sd3_e.neg[i] && (sd3_e.mag[i] != 32'd0);
			end
			for (int k = 0; k < 6; k++) begin
				prodc_s6[k] <= 64'(sd3_e.cm[k]) * 64'(k_fac);
			end
			root_s6      <= sd3_e.root;
			sd4_s6.cneg  <= sd3_e.cneg;
			sd4_s6.p     <= sd3_e.p;
			sd4_s6.p2    <= (pp_sh > 64'(CAP_M32)) ? CAP_M32 : pp_sh[31:0];
			sd4_s6.lapse <= sd3_e.lapse;
		end
	end

	// Third division round: derivatives over the radius.
	logic [QW-1:0] q_d [3];
	logic          o_d [3];
	logic [QW-1:0] q_dd [6];
	logic          o_dd [6];

	for (genvar i = 0; i < 3; i++) begin : g_div_d
		sip_div u_div_d (
			.clk (clk), .en (en),
			.num (NW'(prodm_s6[i])), .den (DW'(root_s6)),
			.quo (q_d[i]), .ovf (o_d[i])
		);
	end

	for (genvar k = 0; k < 6; k++) begin : g_div_dd
		sip_div u_div_dd (
			.clk (clk), .en (en),
			.num (NW'(prodc_s6[k])), .den (DW'(root_s6)),
			.quo (q_dd[k]), .ovf (o_dd[k])
		);
	end

	sd4_t sd4_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sd4_q[0] <= sd4_s6;
			for (int k = 1; k < DIV_LAT; k++) sd4_q[k] <= sd4_q[k-1];
		end
	end

	// Stage 7: output register, selecting by mode.
	sd4_t             sd4_e;
	logic [63:0]      p4;
	logic [31:0]      gb_fold;
	logic [2:0][31:0] dpsi;
	logic [5:0][31:0] ddpsi;
	res_t             res_s7;

	assign sd4_e   = sd4_q[DIV_LAT-1];
	assign p4      = (64'(sd4_e.p2) * 64'(sd4_e.p2)) >> FRAC_BITS;
	assign gb_fold = (p4 > 64'(CAP_SMAX)) ? CAP_SMAX : p4[31:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dpsi[i] = pack_s(sd4_e.dneg[i], capq(o_d[i], q_d[i], CAP_SMIN));
		end
		for (int k = 0; k < 6; k++) begin
			ddpsi[k] = pack_s(sd4_e.cneg[k], capq(o_dd[k], q_dd[k], CAP_SMIN));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s7.lapse <= sd4_e.lapse;
			if (cfg.conformal_mode) begin
				res_s7.psi_out  <= sd4_e.p;
				res_s7.gb_diag  <= ONE;
				res_s7.dpsi_x   <= dpsi[0];
				res_s7.dpsi_y   <= dpsi[1];
				res_s7.dpsi_z   <= dpsi[2];
				res_s7.ddpsi_xx <= ddpsi[0];
				res_s7.ddpsi_xy <= ddpsi[1];
				res_s7.ddpsi_xz <= ddpsi[2];
				res_s7.ddpsi_yy <= ddpsi[3];
				res_s7.ddpsi_yz <= ddpsi[4];
				res_s7.ddpsi_zz <= ddpsi[5];
			end else begin
				res_s7.psi_out  <= ONE;
				res_s7.gb_diag  <= gb_fold;
				res_s7.dpsi_x   <= '0;
				res_s7.dpsi_y   <= '0;
				res_s7.dpsi_z   <= '0;
				res_s7.ddpsi_xx <= '0;
				res_s7.ddpsi_xy <= '0;
				res_s7.ddpsi_xz <= '0;
				res_s7.ddpsi_yy <= '0;
				res_s7.ddpsi_yz <= '0;
				res_s7.ddpsi_zz <= '0;
			end
		end
	end

	assign res_data = res_s7;

endmodule

@@ tb/schwarzschild_isotropic_point_tb.sv @@
module schwarzschild_isotropic_point_tb;
	import sip_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 135;
	localparam logic [63:0] U32 = 64'hFFFF_FFFF;
	localparam logic [63:0] S_MAX = 64'h7FFF_FFFF;
	localparam logic [63:0] S_MIN_MAG = 64'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	pt_t pt_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	schwarzschild_isotropic_point u_dut (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration.
	logic [30:0] bh_mass = 31'(64'd1 << FRAC_BITS);
	logic conformal = 1'b1;

	pt_t point_q[$];
	res_t fields_q[$];
	int pt_gap_pct = 13;
	int res_hold_pct = 87;
	bit long_hold = 1'b0;
	bit hold_start = 1'b0;
	bit pt_taken = 1'b0;
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;

	// min(floor(a * 2^sh / b), cap) by restoring long division.
	function automatic logic [63:0] fix_div(logic [63:0] a, logic [63:0] b, int sh,
			logic [63:0] cap);
		logic [63:0] q;
		logic [63:0] rem;
		if (b == 0)
			return cap;
		q = a / b;
		rem = a % b;
		if (q > cap)
			return cap;
		for (int i = 0; i < sh; i++) begin
			if (rem >= b - rem) begin
				rem = rem - (b - rem);
				q = 2 * q + 1;
			end else begin
				rem = rem + rem;
				q = 2 * q;
			end
			if (q > cap)
				return cap;
		end
		return q;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] to_signed_sat(bit neg, logic [63:0] mag);
		if (neg) begin
			if (mag > S_MIN_MAG)
				mag = S_MIN_MAG;
			return 32'(64'd0 - mag);
		end
		return (mag > S_MAX) ? 32'(S_MAX) : 32'(mag);
	endfunction

	// Expected field set for one grid point under the current mass and mode.
	function automatic res_t isotropic_fields(pt_t p);
		res_t o;
		logic [31:0] outs [12];
		logic [63:0] mag [3];
		bit neg [3];
		logic [31:0] c [3];
		logic [63:0] one, r2, rad, dd, num, w, kk, p1, p2, p4, t, cm;
		logic [63:0] m;
		bit lneg, cneg;
		int k;
		one = 64'd1 << FRAC_BITS;
		m = 64'(bh_mass);
		c[0] = p.x_pos;
		c[1] = p.y_pos;
		c[2] = p.z_pos;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i][31];
			mag[i] = neg[i] ? (64'h1_0000_0000 - 64'(c[i])) : 64'(c[i]);
		end
		r2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		rad = int_sqrt(r2);
		if (rad == 0)
			rad = 1;
		dd = 2 * rad + m;
		lneg = m > 2 * rad;
		num = lneg ? m - 2 * rad : 2 * rad - m;
		outs[1] = to_signed_sat(lneg, fix_div(num, dd, FRAC_BITS, S_MIN_MAG));
		if (conformal) begin
			outs[0] = to_signed_sat(1'b0, fix_div(dd, 2 * rad, FRAC_BITS, S_MAX));
			outs[2] = 32'(one);
			w = fix_div(m, dd, FRAC_BITS, one);
			kk = fix_div(w, rad, FRAC_BITS, U32);
			for (int i = 0; i < 3; i++)
				outs[3 + i] = to_signed_sat(!neg[i] && mag[i] != 0,
					fix_div(mag[i] * kk, rad, 0, S_MIN_MAG));
			k = 6;
			for (int a = 0; a < 3; a++) begin
				for (int b = a; b < 3; b++) begin
					t = fix_div(3 * mag[a] * mag[b], (r2 != 0) ? r2 : 64'd1,
						FRAC_BITS, 3 * one);
					cneg = (neg[a] != neg[b]) && t != 0;
					cm = t;
					if (a == b) begin
						cneg = t < one;
						cm = cneg ? one - t : t - one;
					end
					outs[k] = to_signed_sat(cneg && cm != 0,
						fix_div(cm * kk, rad, 0, S_MIN_MAG));
					k++;
				end
			end
		end else begin
			p1 = fix_div(dd, 2 * rad, FRAC_BITS, U32);
			p2 = (p1 * p1) >> FRAC_BITS;
			if (p2 > U32)
				p2 = U32;
			p4 = (p2 * p2) >> FRAC_BITS;
			outs[0] = 32'(one);
			outs[2] = to_signed_sat(1'b0, p4);
			for (int i = 3; i < 12; i++)
				outs[i] = '0;
		end
		o.psi_out = outs[0];
		o.lapse = outs[1];
		o.gb_diag = outs[2];
		o.dpsi_x = outs[3];
		o.dpsi_y = outs[4];
		o.dpsi_z = outs[5];
		o.ddpsi_xx = outs[6];
		o.ddpsi_xy = outs[7];
		o.ddpsi_xz = outs[8];
		o.ddpsi_yy = outs[9];
		o.ddpsi_yz = outs[10];
		o.ddpsi_zz = outs[11];
		return o;
	endfunction

	// Records whether the point beat was taken at this rising edge.
	always @(posedge clk) begin
		pt_taken <= arst_n && pt_valid && !pt_stall;
	end

	// Point driver: offers the head of the queue, moves on after each accepted beat.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pt_taken) begin
				fields_q.push_back(isotropic_fields(pt_data));
				beats_in++;
				void'(point_q.pop_front());
			end
			if ((pt_valid && !pt_taken) || (point_q.size() > 0 &&
					$urandom_range(99) >= pt_gap_pct)) begin
				pt_valid <= (point_q.size() > 0);
				if (point_q.size() > 0)
					pt_data <= point_q[0];
			end else begin
				pt_valid <= 1'b0;
				pt_data <= pt_t'({$urandom, $urandom, $urandom});
			end
			res_stall <= long_hold || ($urandom_range(99) < res_hold_pct);
		end
	end

	// Long output hold, counted in cycles once requested.
	initial begin
		wait (hold_start);
		long_hold = 1'b1;
		repeat (LATENCY * 2)
			@(posedge clk);
		long_hold = 1'b0;
	end

	// Result monitor.
	always @(posedge clk) begin
		res_t exp_fields;
		if (arst_n && res_valid && !res_stall) begin
			beats_out++;
			if (fields_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", res_data);
			end else begin
				exp_fields = fields_q.pop_front();
				if (res_data !== exp_fields) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d", beats_out);
						$display("  expected %p", exp_fields);
						$display("  actual   %p", res_data);
					end
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MASS)
			bh_mass = value[30:0];
		else
			conformal = value[0];
	endtask

	task automatic drain();
		while (point_q.size() > 0 || pt_valid || fields_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(65535)) - 32768);
			2: return 32'(($urandom_range(1) ? -1 : 1) * $signed($urandom_range(2000000)));
			default: return 32'(($urandom_range(1) ? -1 : 1) *
				$signed($urandom_range(1 << 24)));
		endcase
	endfunction

	task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		pt_t p;
		p.x_pos = x;
		p.y_pos = y;
		p.z_pos = z;
		point_q.push_back(p);
	endtask

	// Stimulus sequence, run in phases between register writes.
	initial begin
		logic [31:0] masses [6];
		masses = '{32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0000_0001,
			32'h0020_0000, 32'h0000_8000};
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed points under reset settings, then again with conformal mode off.
		push_point(0, 0, 0);
		push_point(32'h0001_0000, 0, 0);
		push_point(0, 32'hFFFF_0000, 0);
		push_point(0, 0, 32'h0000_8000);
		push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_point(32'h8000_0000, 32'h7FFF_FFFF, 0);
		push_point(1, 0, 0);
		push_point(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		push_point(32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000);
		push_point(32'h0000_8000, 32'hFFFF_8000, 0);
		drain();
		reg_write(REG_MODE, 0);
		push_point(0, 0, 0);
		push_point(1, 0, 0);
		push_point(32'h0000_4000, 0, 0);
		push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		push_point(32'h0001_0000, 0, 0);
		drain();

		// Random phases over masses and both modes, idle pattern flips halfway.
		// The long-hold phase sends more points than the pipeline holds.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 6) begin
				pt_gap_pct = 87;
				res_hold_pct = 13;
			end
			if (ph == 10) begin
				pt_gap_pct = 0;
				res_hold_pct = 0;
			end
			reg_write(REG_MASS, (ph < 6) ? masses[ph] : $urandom);
			reg_write(REG_MODE, ph % 2);
			if (ph == 10)
				hold_start = 1'b1;
			repeat ((ph == 10) ? 150 : 44)
				push_point(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		$display("Covered %0d points, %0d results, six mass settings plus random ones,",
			beats_in, beats_out);
		$display("both metric modes, radius zero, extreme coordinates and a long output hold.");
		if (mismatches == 0)
			$display("** schwarzschild_isotropic_point: PASSED **");
		else
			$display("** schwarzschild_isotropic_point: FAILED **");
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("timeout");
		$display("** schwarzschild_isotropic_point: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sip_pkg.sv
hdl/sip_cfg.sv
hdl/sip_sqrt.sv
hdl/sip_div.sv
hdl/schwarzschild_isotropic_point.sv
tb/schwarzschild_isotropic_point_tb.sv
